FILE: rtl/core/nvc_pkg.sv
// ----------------------------------------------------------------------------
// nvc_pkg
// Shared types and constants for the normalized deviation compare core.
// ----------------------------------------------------------------------------
package nvc_pkg;

  // Fixed field and sum widths
  localparam int SAMPLE_PORT_W = 16;
  localparam int DIFF_SUM_W    = 43;
  localparam int MODEL_SUM_W   = 41;
  localparam int RESULT_W      = 16;

  // Saturation caps of the two sums
  localparam logic [DIFF_SUM_W-1:0]  DIFF_CAP  = '1;
  localparam logic [MODEL_SUM_W-1:0] MODEL_CAP = '1;

  // Search range: the result is searched in 0 .. 65536, 65536 meaning "too large"
  localparam int SEARCH_W = RESULT_W + 1;
  localparam logic [SEARCH_W-1:0] SEARCH_HI  = SEARCH_W'(1) << RESULT_W;
  localparam logic [RESULT_W-1:0] RESULT_MAX = '1;

  // 4 * 10000^2, the scaled right-hand side factor of the search compare
  localparam int SCALE4_W = 29;
  localparam logic [SCALE4_W-1:0] SCALE4 = 29'd400000000;

  // Sums of one finished vector, handed from front to back
  typedef struct packed {
    logic                   overflow;
    logic [MODEL_SUM_W-1:0] model_sum;
    logic [DIFF_SUM_W-1:0]  diff_sum;
  } nvc_sums_t;

endpackage

FILE: rtl/core/nvc_front.sv
// ----------------------------------------------------------------------------
// nvc_front
// Accepts sample pairs, squares them and keeps two saturating sums; on the
// last pair of a vector pushes the sums into the queue and clears them.
// ----------------------------------------------------------------------------
module nvc_front
  import nvc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_PORT_W-1:0] target_sample,
  input  logic signed [SAMPLE_PORT_W-1:0] model_sample,
  input  logic                            last_sample,
  input  logic                            q_full,
  output logic                            q_push,
  output nvc_sums_t                       q_push_data
);

  localparam int RAW_W = (SAMPLE_BITS > SAMPLE_PORT_W) ? SAMPLE_BITS : SAMPLE_PORT_W;
  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int DW    = ((DIFF_SUM_W > SQ_W) ? DIFF_SUM_W : SQ_W) + 1;
  localparam int MW    = ((MODEL_SUM_W > SQ_W) ? MODEL_SUM_W : SQ_W) + 1;

  logic [RAW_W-1:0]         t_raw;
  logic [RAW_W-1:0]         m_raw;
  logic signed [SAMPLE_BITS:0] t_x;
  logic signed [SAMPLE_BITS:0] m_x;
  logic signed [SAMPLE_BITS:0] d_x;
  logic [SAMPLE_BITS:0]     d_abs;
  logic [SAMPLE_BITS:0]     m_abs;
  logic [SAMPLE_BITS-1:0]   d_mag;
  logic [SAMPLE_BITS-1:0]   m_mag;

  logic                     s1_valid;
  logic                     s1_last;
  logic [SQ_W-1:0]          s1_dsq;
  logic [SQ_W-1:0]          s1_msq;

  logic [DIFF_SUM_W-1:0]    diff_sum;
  logic [MODEL_SUM_W-1:0]   model_sum;
  logic                     sum_ovf;

  logic [DW-1:0]            d_tot;
  logic [MW-1:0]            m_tot;
  logic                     d_sat;
  logic                     m_sat;
  logic [DIFF_SUM_W-1:0]    diff_sum_next;
  logic [MODEL_SUM_W-1:0]   model_sum_next;
  logic                     sum_ovf_next;
  logic                     acc_step;

  // Take the low SAMPLE_BITS bits of each sample as two's complement
  assign t_raw = RAW_W'($unsigned(target_sample));
  assign m_raw = RAW_W'($unsigned(model_sample));
  assign t_x   = {t_raw[SAMPLE_BITS-1], t_raw[SAMPLE_BITS-1:0]};
  assign m_x   = {m_raw[SAMPLE_BITS-1], m_raw[SAMPLE_BITS-1:0]};
  assign d_x   = t_x - m_x;

  // Magnitudes fit in SAMPLE_BITS bits
  assign d_abs = d_x[SAMPLE_BITS] ? $unsigned(-d_x) : $unsigned(d_x);
  assign m_abs = m_x[SAMPLE_BITS] ? $unsigned(-m_x) : $unsigned(m_x);
  assign d_mag = d_abs[SAMPLE_BITS-1:0];
  assign m_mag = m_abs[SAMPLE_BITS-1:0];

  // Advance the accumulate stage; a last pair waits for a queue slot
  assign acc_step = s1_valid && (!s1_last || !q_full);
  assign in_ready = !s1_valid || acc_step;

  // Square stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_last <= last_sample;
      s1_dsq  <= d_mag * d_mag;
      s1_msq  <= m_mag * m_mag;
    end
  end

  // Saturating add of both squares
  always_comb begin
    d_tot          = DW'(diff_sum) + DW'(s1_dsq);
    m_tot          = MW'(model_sum) + MW'(s1_msq);
    d_sat          = d_tot > DW'(DIFF_CAP);
    m_sat          = m_tot > MW'(MODEL_CAP);
    diff_sum_next  = d_sat ? DIFF_CAP : d_tot[DIFF_SUM_W-1:0];
    model_sum_next = m_sat ? MODEL_CAP : m_tot[MODEL_SUM_W-1:0];
    sum_ovf_next   = sum_ovf || d_sat || m_sat;
  end

  // Hand off the finished vector
  assign q_push                = acc_step && s1_last;
  assign q_push_data.overflow  = sum_ovf_next;
  assign q_push_data.model_sum = model_sum_next;
  assign q_push_data.diff_sum  = diff_sum_next;

  // Accumulate, clear after the last pair
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_sum  <= '0;
      model_sum <= '0;
      sum_ovf   <= 1'b0;
    end else if (acc_step) begin
      if (s1_last) begin
        diff_sum  <= '0;
        model_sum <= '0;
        sum_ovf   <= 1'b0;
      end else begin
        diff_sum  <= diff_sum_next;
        model_sum <= model_sum_next;
        sum_ovf   <= sum_ovf_next;
      end
    end
  end

  // Sums start over after each vector
  a_clear_after_push: assert property (@(posedge clk) disable iff (rst)
    q_push |=> (diff_sum == '0 && model_sum == '0 && !sum_ovf))
    else $error("sums not cleared after vector hand-off");

endmodule

FILE: rtl/core/nvc_queue.sv
// ----------------------------------------------------------------------------
// nvc_queue
// Short queue of finished vector sums between front and back; read data is
// registered and valid in the cycle after a pop.
// ----------------------------------------------------------------------------
module nvc_queue
  import nvc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  nvc_sums_t push_data,
  input  logic      pop,
  output nvc_sums_t rd_data,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nvc_sums_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;

  // Pointer wrap helper
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  // Write side
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("queue pushed when full or popped when empty");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue level beyond depth");

endmodule

FILE: rtl/core/nvc_back.sv
// ----------------------------------------------------------------------------
// nvc_back
// Pops vector sums and finds round_half_up(10000*sqrt(E/J)) by a binary search
// of up to 17 steps; each step tests (2n-1)^2 * J <= 4e8 * E on one shared
// 34x22 multiplier, two partial products per wide product.
// ----------------------------------------------------------------------------
module nvc_back
  import nvc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                q_pop,
  input  nvc_sums_t           q_rd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RESULT_W-1:0] nrmsd_e4,
  output logic                saturated,
  output logic                zero_reference
);

  localparam int LO_W   = 22;
  localparam int OSQ_W  = 2 * SEARCH_W;
  localparam int PROD_W = OSQ_W + LO_W;
  localparam int ACC_W  = PROD_W + LO_W;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_LOAD = 9'b000000010,
    ST_RHS0 = 9'b000000100,
    ST_RHS1 = 9'b000001000,
    ST_SQ   = 9'b000010000,
    ST_MUL0 = 9'b000100000,
    ST_MUL1 = 9'b001000000,
    ST_CMP  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } nvc_back_state_t;

  nvc_back_state_t       state;
  nvc_back_state_t       state_next;

  logic [DIFF_SUM_W-1:0]  e_sum;
  logic [MODEL_SUM_W-1:0] j_sum;
  logic                   ovf;
  logic [SEARCH_W-1:0]    lo;
  logic [SEARCH_W-1:0]    hi;
  logic [SEARCH_W-1:0]    mid;
  logic [OSQ_W-1:0]       odd_sq;
  logic [ACC_W-1:0]       acc;
  logic [ACC_W-1:0]       rhs;
  logic [RESULT_W-1:0]    res;
  logic                   res_sat;
  logic                   res_zero;

  logic [SEARCH_W:0]      mid_sum;
  logic [SEARCH_W-1:0]    mid_next;
  logic [SEARCH_W-1:0]    odd;
  logic [OSQ_W-1:0]       mul_a;
  logic [LO_W-1:0]        mul_b;
  logic [PROD_W-1:0]      prod;
  logic [ACC_W-1:0]       acc_hi_sum;
  logic                   hit;
  logic [SEARCH_W-1:0]    lo_next;
  logic [SEARCH_W-1:0]    hi_next;
  logic                   out_free;

  // Next probe and its odd factor 2n-1
  assign mid_sum  = (SEARCH_W + 1)'(lo) + (SEARCH_W + 1)'(hi) + (SEARCH_W + 1)'(1);
  assign mid_next = mid_sum[SEARCH_W:1];
  assign odd      = {mid_next[SEARCH_W-2:0], 1'b0} - SEARCH_W'(1);

  // Shared multiplier operands
  always_comb begin
    mul_a = odd_sq;
    mul_b = j_sum[LO_W-1:0];
    case (state)
      ST_RHS0: begin
        mul_a = OSQ_W'(SCALE4);
        mul_b = e_sum[LO_W-1:0];
      end
      ST_RHS1: begin
        mul_a = OSQ_W'(SCALE4);
        mul_b = LO_W'(e_sum[DIFF_SUM_W-1:LO_W]);
      end
      ST_MUL1: begin
        mul_b = LO_W'(j_sum[MODEL_SUM_W-1:LO_W]);
      end
      default: begin
        mul_b = j_sum[LO_W-1:0];
      end
    endcase
  end

  assign prod       = mul_a * mul_b;
  assign acc_hi_sum = acc + (ACC_W'(prod) << LO_W);

  // Search step outcome
  assign hit     = acc <= rhs;
  assign lo_next = hit ? mid : lo;
  assign hi_next = hit ? hi : mid - SEARCH_W'(1);

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (!q_empty) state_next = ST_LOAD;
      ST_LOAD: state_next = (q_rd_data.model_sum == '0) ? ST_FIN : ST_RHS0;
      ST_RHS0: state_next = ST_RHS1;
      ST_RHS1: state_next = ST_SQ;
      ST_SQ:   state_next = ST_MUL0;
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_CMP;
      ST_CMP:  state_next = (lo_next < hi_next) ? ST_SQ : ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        e_sum    <= q_rd_data.diff_sum;
        j_sum    <= q_rd_data.model_sum;
        ovf      <= q_rd_data.overflow;
        lo       <= '0;
        hi       <= SEARCH_HI;
        res      <= '0;
        res_sat  <= q_rd_data.overflow;
        res_zero <= q_rd_data.model_sum == '0;
      end
      ST_RHS0: acc <= ACC_W'(prod);
      ST_RHS1: rhs <= acc_hi_sum;
      ST_SQ: begin
        mid    <= mid_next;
        odd_sq <= odd * odd;
      end
      ST_MUL0: acc <= ACC_W'(prod);
      ST_MUL1: acc <= acc_hi_sum;
      ST_CMP: begin
        lo <= lo_next;
        hi <= hi_next;
        if (lo_next[RESULT_W]) begin
          res     <= RESULT_MAX;
          res_sat <= 1'b1;
        end else begin
          res     <= lo_next[RESULT_W-1:0];
          res_sat <= ovf;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      nrmsd_e4       <= res;
      saturated      <= res_sat;
      zero_reference <= res_zero;
    end
  end

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ || state == ST_CMP) |-> (lo < hi && hi <= SEARCH_HI))
    else $error("search window out of order");

  a_probe_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (mid > lo && mid <= hi))
    else $error("probe outside search window");

  a_zero_ref_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_reference) |-> (nrmsd_e4 == '0))
    else $error("zero reference result not zero");

endmodule

FILE: rtl/core/nrmsd_vector_compare_core.sv
// ----------------------------------------------------------------------------
// nrmsd_vector_compare_core
// Normalized RMS deviation of paired sample vectors, in units of 0.0001.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_ready   target_sample, model_sample, last_sample
//   out      out  out_valid/out_ready nrmsd_e4, saturated, zero_reference
//
// The front takes one sample pair per cycle; squares are registered in the
// square stage and added into the sums in the accumulate stage. The back runs
// up to 17 search steps per vector on its one shared multiplier, each through
// ST_SQ, ST_MUL0, ST_MUL1, ST_CMP. Finished sums wait in a QUEUE_DEPTH-entry queue
// (power of two), so the front stalls only on a last pair while the queue is
// full. Synchronous reset clears sums, queue and sequencer.
// ----------------------------------------------------------------------------
module nrmsd_vector_compare_core
  import nvc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_PORT_W-1:0] target_sample,
  input  logic signed [SAMPLE_PORT_W-1:0] model_sample,
  input  logic                            last_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [RESULT_W-1:0]             nrmsd_e4,
  output logic                            saturated,
  output logic                            zero_reference
);

  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  nvc_sums_t q_push_data;
  nvc_sums_t q_rd_data;

  // Accumulate sample pairs
  nvc_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .target_sample(target_sample),
    .model_sample (model_sample),
    .last_sample  (last_sample),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_data  (q_push_data)
  );

  // Buffer finished vectors
  nvc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .rd_data  (q_rd_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Search for the rounded root ratio
  nvc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_rd_data     (q_rd_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .nrmsd_e4      (nrmsd_e4),
    .saturated     (saturated),
    .zero_reference(zero_reference)
  );

endmodule

FILE: test/nrmsd_checker.sv
// ----------------------------------------------------------------------------
// nrmsd_checker
// Watches both channels of nrmsd_vector_compare_core. It accumulates the two
// sums of squares for every accepted request, predicts the deviation result
// of each finished vector, and compares each accepted result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module nrmsd_checker
  import nvc_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic signed [SAMPLE_PORT_W-1:0] target_sample,
  input  logic signed [SAMPLE_PORT_W-1:0] model_sample,
  input  logic                            last_sample,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [RESULT_W-1:0]             nrmsd_e4,
  input  logic                            saturated,
  input  logic                            zero_reference,
  output int                              pending,
  output int                              fail_count,
  output int                              result_count,
  output int                              sat_count,
  output int                              zref_count
);

  localparam longint unsigned E4_SCALE = 10000;
  localparam int              E4_MAX   = (1 << RESULT_W) - 1;

  typedef struct packed {
    logic [RESULT_W-1:0] value;
    logic                sat;
    logic                zref;
  } deviation_t;

  logic [DIFF_SUM_W-1:0]  diff_acc;
  logic [MODEL_SUM_W-1:0] model_acc;
  logic                   acc_ovf;
  deviation_t             deviation_q[$];

  // Find the largest n with (2n-1)^2 * j <= 4 * 10000^2 * e, which is
  // 10000 * sqrt(e / j) rounded half up, then clamp it to the result width.
  function automatic deviation_t deviation_e4(input logic [DIFF_SUM_W-1:0]  e,
                                              input logic [MODEL_SUM_W-1:0] j,
                                              input logic                   ovf);
    deviation_t   r;
    int           lo;
    int           hi;
    int           mid;
    logic [127:0] odd;
    logic [127:0] lhs;
    logic [127:0] rhs;
    r.value = '0;
    r.sat   = ovf;
    r.zref  = 1'b0;
    if (j == '0) begin
      r.zref = 1'b1;
      return r;
    end
    lo  = 0;
    hi  = E4_MAX + 1;
    rhs = 128'(4 * E4_SCALE * E4_SCALE) * 128'(e);
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 128'(2 * mid - 1);
      lhs = odd * odd * 128'(j);
      if (lhs <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    if (lo > E4_MAX) begin
      lo    = E4_MAX;
      r.sat = 1'b1;
    end
    r.value = RESULT_W'(lo);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    longint     dl;
    longint     ml;
    logic [63:0] dsum;
    logic [63:0] msum;
    deviation_t got;
    deviation_t want;
    if (rst) begin
      diff_acc  = '0;
      model_acc = '0;
      acc_ovf   = 1'b0;
      deviation_q.delete();
      fail_count   = 0;
      result_count = 0;
      sat_count    = 0;
      zref_count   = 0;
    end else begin
      // Compare an accepted result with the oldest prediction
      if (out_valid && out_ready) begin
        got = '{nrmsd_e4, saturated, zero_reference};
        result_count++;
        if (saturated === 1'b1) sat_count++;
        if (zero_reference === 1'b1) zref_count++;
        if (deviation_q.size() == 0) begin
          $display("%0t: result with none pending: nrmsd_e4=%0d saturated=%b zero_reference=%b",
                   $time, got.value, got.sat, got.zref);
          fail_count++;
        end else begin
          want = deviation_q[0];
          deviation_q.delete(0);
          if (got.value !== want.value) begin
            $display("%0t: nrmsd_e4 mismatch: expected %0d, actual %0d",
                     $time, want.value, got.value);
            fail_count++;
          end
          if (got.sat !== want.sat) begin
            $display("%0t: saturated mismatch: expected %b, actual %b",
                     $time, want.sat, got.sat);
            fail_count++;
          end
          if (got.zref !== want.zref) begin
            $display("%0t: zero_reference mismatch: expected %b, actual %b",
                     $time, want.zref, got.zref);
            fail_count++;
          end
        end
      end

      // Accumulate an accepted request, saturating each sum at its cap
      if (in_valid && in_ready) begin
        dl   = longint'(target_sample) - longint'(model_sample);
        ml   = longint'(model_sample);
        dsum = 64'(diff_acc) + 64'(dl * dl);
        msum = 64'(model_acc) + 64'(ml * ml);
        if (dsum > 64'(DIFF_CAP)) begin
          diff_acc = DIFF_CAP;
          acc_ovf  = 1'b1;
        end else begin
          diff_acc = dsum[DIFF_SUM_W-1:0];
        end
        if (msum > 64'(MODEL_CAP)) begin
          model_acc = MODEL_CAP;
          acc_ovf   = 1'b1;
        end else begin
          model_acc = msum[MODEL_SUM_W-1:0];
        end
        // Close the vector: predict its result and clear the sums
        if (last_sample) begin
          deviation_q.push_back(deviation_e4(diff_acc, model_acc, acc_ovf));
          diff_acc  = '0;
          model_acc = '0;
          acc_ovf   = 1'b0;
        end
      end
    end
    pending <= deviation_q.size();
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for nrmsd_vector_compare_core. Sends directed vectors
// (extremes, exact match, zero reference, rounding and range edges), then
// random vectors of mixed shape, with random gaps on the sender and random
// stalls on the receiver.
// ----------------------------------------------------------------------------
module tb;
  import nvc_pkg::*;

  localparam int RANDOM_PAIRS  = 480;
  localparam int DRAIN_EVERY   = 120;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic signed [SAMPLE_PORT_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_PORT_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum int {
    SHAPE_FULL,
    SHAPE_NEAR,
    SHAPE_ZERO_MODEL,
    SHAPE_TINY_MODEL,
    SHAPE_EQUAL
  } vector_shape_t;

  logic                            clk         = 1'b0;
  logic                            rst         = 1'b1;
  logic                            in_valid    = 1'b0;
  logic signed [SAMPLE_PORT_W-1:0] target_sample = '0;
  logic signed [SAMPLE_PORT_W-1:0] model_sample  = '0;
  logic                            last_sample = 1'b0;
  logic                            out_ready   = 1'b0;
  logic                            in_ready;
  logic                            out_valid;
  logic [RESULT_W-1:0]             nrmsd_e4;
  logic                            saturated;
  logic                            zero_reference;

  int   pending;
  int   fail_count;
  int   result_count;
  int   sat_count;
  int   zref_count;
  int   pairs_sent   = 0;
  int   vectors_sent = 0;
  int   cycles       = 0;
  int   stall_left   = 0;
  logic tx_calm      = 1'b0;
  logic rx_calm      = 1'b0;

  nrmsd_vector_compare_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .target_sample  (target_sample),
    .model_sample   (model_sample),
    .last_sample    (last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .nrmsd_e4       (nrmsd_e4),
    .saturated      (saturated),
    .zero_reference (zero_reference)
  );

  nrmsd_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .target_sample  (target_sample),
    .model_sample   (model_sample),
    .last_sample    (last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .nrmsd_e4       (nrmsd_e4),
    .saturated      (saturated),
    .zero_reference (zero_reference),
    .pending        (pending),
    .fail_count     (fail_count),
    .result_count   (result_count),
    .sat_count      (sat_count),
    .zref_count     (zref_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 90);
  endfunction

  // Stall the result channel at random unless calm
  always @(posedge clk) begin : result_stall
    int n;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      n = rx_calm ? 0 : idle_len();
      if (n > 0) begin
        out_ready  <= 1'b0;
        stall_left <= n - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one request, hold it until accepted, then maybe idle
  task automatic send_pair(input logic signed [SAMPLE_PORT_W-1:0] t,
                           input logic signed [SAMPLE_PORT_W-1:0] m,
                           input logic                            last);
    int gap;
    in_valid      <= 1'b1;
    target_sample <= t;
    model_sample  <= m;
    last_sample   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
    if (last) vectors_sent++;
    gap = tx_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off new requests until every pending result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Send one vector of random content in the given shape
  task automatic send_random_vector(input vector_shape_t shape, input int len);
    logic signed [SAMPLE_PORT_W-1:0] t;
    logic signed [SAMPLE_PORT_W-1:0] m;
    for (int i = 0; i < len; i++) begin
      m = SAMPLE_PORT_W'($urandom);
      t = SAMPLE_PORT_W'($urandom);
      case (shape)
        SHAPE_NEAR: begin
          t = SAMPLE_PORT_W'(int'(m) + $urandom_range(0, 600) - 300);
        end
        SHAPE_ZERO_MODEL: begin
          m = '0;
          if ($urandom_range(0, 3) == 0) t = '0;
        end
        SHAPE_TINY_MODEL: begin
          m = SAMPLE_PORT_W'(int'($urandom_range(0, 6)) - 3);
        end
        SHAPE_EQUAL: begin
          t = m;
        end
        default: begin
        end
      endcase
      send_pair(t, m, i == len - 1);
    end
  endtask

  initial begin : stimulus
    vector_shape_t shape;
    int            len;
    int            r;
    int            random_pairs;
    int            next_drain;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, exact match, zero reference, range and rounding edges
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
    send_pair(SAMPLE_MAX, 16'sd1, 1'b1);
    send_pair(SAMPLE_MIN, -16'sd1, 1'b1);
    send_pair(SAMPLE_MAX, 16'sd0, 1'b0);
    send_pair(SAMPLE_MIN, 16'sd0, 1'b0);
    send_pair(16'sd1, 16'sd0, 1'b1);
    send_pair(16'sd755, 16'sd100, 1'b1);
    send_pair(16'sd756, 16'sd100, 1'b1);
    send_pair(16'sd20001, 16'sd20000, 1'b1);
    send_pair(-16'sd19999, -16'sd20000, 1'b1);
    send_pair(16'sd20003, 16'sd20000, 1'b1);
    send_pair(-16'sd1, 16'sd1, 1'b0);
    send_pair(16'sd1, -16'sd1, 1'b0);
    send_pair(16'sd12345, -16'sd4321, 1'b0);
    send_pair(-16'sd30000, 16'sd29999, 1'b1);
    drain();

    // Random vectors, mostly short, with periodic full drains
    random_pairs = 0;
    next_drain   = DRAIN_EVERY;
    while (random_pairs < RANDOM_PAIRS) begin
      r = $urandom_range(0, 99);
      if (r < 35)      shape = SHAPE_FULL;
      else if (r < 70) shape = SHAPE_NEAR;
      else if (r < 80) shape = SHAPE_ZERO_MODEL;
      else if (r < 90) shape = SHAPE_TINY_MODEL;
      else             shape = SHAPE_EQUAL;
      r = $urandom_range(0, 99);
      if (r < 70)      len = $urandom_range(1, 6);
      else if (r < 95) len = $urandom_range(7, 30);
      else             len = $urandom_range(31, 120);
      tx_calm = ($urandom_range(0, 9) == 0);
      rx_calm <= ($urandom_range(0, 9) == 0);
      send_random_vector(shape, len);
      random_pairs += len;
      if (random_pairs >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end
    end

    // Let every result out, then watch a while for strays
    tx_calm = 1'b1;
    rx_calm <= 1'b1;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d sample pairs in %0d vectors: directed edges, then random shapes.",
             pairs_sent, vectors_sent);
    $display("Checked %0d results: %0d saturated, %0d with zero reference.",
             result_count, sat_count, zref_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
